>>> rtl/resp_request_deframer_assert.svh
// ----------------------------------------------------------------------------
// RESP request deframer assertion macros
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_DEFRAMER_ASSERT_SVH
`define RESP_REQUEST_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrd check failed");
// next-cycle implication
`define RRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrd check failed");
`else
`define RRD_ASSERT_IMP(lbl, ante, cons)
`define RRD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Types, codes and sizes shared by the RESP request deframer modules.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int MAX_ARGS      = 1024;
  localparam int LENGTH_BITS   = 27;
  localparam int ARG_BITS      = $clog2(MAX_ARGS + 1);
  localparam int IDX_BITS      = 10;
  localparam int NUM_BITS      = 31;
  localparam int CFG_DATA_BITS = 27;
  localparam int CRLF_LEN      = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] ROLE_TYPE    = 3'd0;
  localparam logic [2:0] ROLE_NUM     = 3'd1;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd2;
  localparam logic [2:0] ROLE_CRLF    = 3'd3;
  localparam logic [2:0] ROLE_DISCARD = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PROTOCOL = 2'd1;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd2;

  localparam logic CFG_MAX_REQUEST_LENGTH = 1'b0;
  localparam logic CFG_MAX_ARGUMENTS      = 1'b1;

  localparam logic [LENGTH_BITS-1:0] MAX_REQUEST_LENGTH_RST = LENGTH_BITS'(2097152);
  localparam logic [ARG_BITS-1:0]    MAX_ARGUMENTS_RST      = ARG_BITS'(1024);

  typedef enum logic [2:0] {
    CLS_STAR, CLS_DOLLAR, CLS_COLON, CLS_MINUS,
    CLS_CR, CLS_LF, CLS_DIGIT, CLS_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    PH_STAR, PH_TYPE, PH_NUM_FIRST, PH_NUM_MORE, PH_NUM_LF,
    PH_PAYLOAD, PH_PAY_CR, PH_PAY_LF, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STAR, KIND_LEN, KIND_INT
  } kind_t;

  typedef enum logic [3:0] {
    ACT_DISCARD, ACT_ERR_PROTO, ACT_ERR_SIZE, ACT_STAR_MARK, ACT_LEN_MARK,
    ACT_INT_MARK, ACT_SIGN, ACT_DIGIT, ACT_NUM_CR, ACT_STAR_EMPTY,
    ACT_STAR_DONE, ACT_LEN_DONE, ACT_ARG_DONE, ACT_PAYLOAD, ACT_PAY_CR
  } action_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]          echo_byte;
    logic [2:0]          role;
    logic [IDX_BITS-1:0] argument_index;
    logic                argument_end;
    logic                request_end;
    logic [1:0]          error_code;
  } tag_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
    cls_t       cls;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_write_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_read_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] max_request_length;
    logic [ARG_BITS-1:0]    max_arguments;
  } cfg_t;

endpackage

>>> rtl/resp_request_deframer.sv
// ----------------------------------------------------------------------------
// resp_request_deframer
// Tags each byte of a RESP request stream with role, argument index,
// end marks and a sticky error code.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------
//   byte    | in        | byte_valid / byte_stall | byte_item (byte_item_t)
//   tag     | out       | tag_valid / tag_stall   | tag_item (tag_item_t)
//   cfg     | in        | cfg_write               | cfg_index, cfg_data
//
// One byte per cycle sustained while tag_stall is low; a byte that is taken is
// classified into the 4-deep queue, then parsed into the output register, where
// its tag is valid on the tag channel. The per-byte state update sets the rate.
// rst is synchronous; it clears parse state and loads the limit defaults.
// tag_stall holds the output register; the queue absorbs up to four bytes
// before byte_stall rises.
// ----------------------------------------------------------------------------
module resp_request_deframer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  rrd_pkg::byte_item_t                  byte_item,
  output logic                                 tag_valid,
  input  logic                                 tag_stall,
  output rrd_pkg::tag_item_t                   tag_item,
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [rrd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  rrd_pkg::cfg_t     cfg;
  rrd_pkg::q_write_t q_wr;
  rrd_pkg::q_read_t  q_rd;
  logic              q_full;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_request_length <= rrd_pkg::MAX_REQUEST_LENGTH_RST;
      cfg.max_arguments      <= rrd_pkg::MAX_ARGUMENTS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rrd_pkg::CFG_MAX_REQUEST_LENGTH:
          cfg.max_request_length <= cfg_data[rrd_pkg::LENGTH_BITS-1:0];
        rrd_pkg::CFG_MAX_ARGUMENTS:
          cfg.max_arguments <= cfg_data[rrd_pkg::ARG_BITS-1:0];
        default: ;
      endcase
    end
  end

  rrd_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .wr         (q_wr)
  );

  rrd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .rd   (q_rd),
    .pop  (q_pop)
  );

  rrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rd        (q_rd),
    .pop       (q_pop),
    .tag_valid (tag_valid),
    .tag_stall (tag_stall),
    .tag_item  (tag_item)
  );

endmodule

>>> rtl/rrd_front.sv
// ----------------------------------------------------------------------------
// rrd_front
// Input side: takes bytes off the stream and classifies each one for the parser.
// ----------------------------------------------------------------------------
module rrd_front (
  input  logic                byte_valid,
  output logic                byte_stall,
  input  rrd_pkg::byte_item_t byte_item,
  input  logic                q_full,
  output rrd_pkg::q_write_t   wr
);

  function automatic rrd_pkg::cls_t classify(input logic [7:0] b);
    rrd_pkg::cls_t c;
    if (b == rrd_pkg::CH_STAR)                c = rrd_pkg::CLS_STAR;
    else if (b == rrd_pkg::CH_DOLLAR)         c = rrd_pkg::CLS_DOLLAR;
    else if (b == rrd_pkg::CH_COLON)          c = rrd_pkg::CLS_COLON;
    else if (b == rrd_pkg::CH_MINUS)          c = rrd_pkg::CLS_MINUS;
    else if (b == rrd_pkg::CH_CR)             c = rrd_pkg::CLS_CR;
    else if (b == rrd_pkg::CH_LF)             c = rrd_pkg::CLS_LF;
    else if (b >= 8'h30 && b <= 8'h39)        c = rrd_pkg::CLS_DIGIT;
    else                                      c = rrd_pkg::CLS_OTHER;
    return c;
  endfunction

  assign byte_stall = q_full;

  always_comb begin
    wr.valid                = byte_valid && !q_full;
    wr.entry.data_byte      = byte_item.data_byte;
    wr.entry.new_connection = byte_item.new_connection;
    wr.entry.cls            = classify(byte_item.data_byte);
  end

endmodule

>>> rtl/rrd_queue.sv
// ----------------------------------------------------------------------------
// rrd_queue
// Small FIFO of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
`include "resp_request_deframer_assert.svh"

module rrd_queue (
  input  logic              clk,
  input  logic              rst,
  input  rrd_pkg::q_write_t wr,
  output logic              full,
  output rrd_pkg::q_read_t  rd,
  input  logic              pop
);

  rrd_pkg::q_entry_t               mem [rrd_pkg::QUEUE_DEPTH];
  logic [rrd_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [rrd_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [rrd_pkg::QUEUE_AW:0]      count;
  logic [rrd_pkg::QUEUE_AW:0]      count_next;

  assign full     = (count == (rrd_pkg::QUEUE_AW + 1)'(rrd_pkg::QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.entry = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr.valid && !pop) count_next = count + 1'b1;
    else if (!wr.valid && pop) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr.valid) mem[wr_ptr] <= wr.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  `RRD_ASSERT_IMP(a_count_bound, 1'b1, count <= (rrd_pkg::QUEUE_AW + 1)'(rrd_pkg::QUEUE_DEPTH))
  `RRD_ASSERT_IMP(a_pop_nonempty, pop, rd.valid)
  `RRD_ASSERT_NXT(a_push_grows, wr.valid && !pop, count == $past(count) + 1'b1)

endmodule

>>> rtl/rrd_back.sv
// ----------------------------------------------------------------------------
// rrd_back
// RESP parser: tags one queued byte per cycle into the output reg unless stalled.
// ----------------------------------------------------------------------------
`include "resp_request_deframer_assert.svh"

module rrd_back (
  input  logic               clk,
  input  logic               rst,
  input  rrd_pkg::cfg_t      cfg,
  input  rrd_pkg::q_read_t   rd,
  output logic               pop,
  output logic               tag_valid,
  input  logic               tag_stall,
  output rrd_pkg::tag_item_t tag_item
);

  localparam int LB = rrd_pkg::LENGTH_BITS;
  localparam int AB = rrd_pkg::ARG_BITS;
  localparam int NB = rrd_pkg::NUM_BITS;

  // parse state
  rrd_pkg::phase_t phase, phase_next, cur_phase;
  rrd_pkg::kind_t  kind, kind_next, cur_kind;
  logic [NB-1:0]   num, num_next, cur_num;
  logic            neg, neg_next, cur_neg;
  logic [AB-1:0]   expected, expected_next, cur_expected;
  logic [AB-1:0]   seen, seen_next, cur_seen;
  logic [LB-1:0]   remaining, remaining_next, cur_remaining;
  logic [LB-1:0]   length, length_next, cur_length;
  logic [1:0]      error_latch, error_next, cur_error;

  rrd_pkg::action_t   act;
  rrd_pkg::tag_item_t res;
  rrd_pkg::cls_t      cls;
  logic               advance;
  logic               clr;
  rrd_pkg::phase_t    clr_phase;

  logic [AB-1:0]   arg_limit;
  logic            len_over;
  logic [LB-1:0]   len_inc;
  logic [NB+3:0]   num_wide;
  logic            num_over;
  logic [NB+1:0]   bulk_sum;
  logic            bulk_over;
  logic            star_bad;
  logic [AB-1:0]   seen_inc;
  logic            all_done;

  assign advance = rd.valid && (!tag_valid || !tag_stall);
  assign pop     = advance;
  assign cls     = rd.entry.cls;

  // new_connection clears parse state and error ahead of the byte
  always_comb begin
    if (rd.entry.new_connection) begin
      cur_phase     = rrd_pkg::PH_STAR;
      cur_kind      = rrd_pkg::KIND_STAR;
      cur_num       = '0;
      cur_neg       = 1'b0;
      cur_expected  = '0;
      cur_seen      = '0;
      cur_remaining = '0;
      cur_length    = '0;
      cur_error     = rrd_pkg::ERR_NONE;
    end else begin
      cur_phase     = phase;
      cur_kind      = kind;
      cur_num       = num;
      cur_neg       = neg;
      cur_expected  = expected;
      cur_seen      = seen;
      cur_remaining = remaining;
      cur_length    = length;
      cur_error     = error_latch;
    end
  end

  always_comb begin
    arg_limit = (cfg.max_arguments > AB'(rrd_pkg::MAX_ARGS)) ?
                AB'(rrd_pkg::MAX_ARGS) : cfg.max_arguments;
    len_over  = ({1'b0, cur_length} + (LB + 1)'(1)) > {1'b0, cfg.max_request_length};
    len_inc   = cur_length + LB'(1);
    // value * 10 + digit as two shifted adds
    num_wide  = (NB + 4)'({cur_num, 3'b000}) + (NB + 4)'({cur_num, 1'b0})
              + (NB + 4)'(rd.entry.data_byte[3:0]);
    num_over  = num_wide > (NB + 4)'(32'h7FFF_FFFF);
    // length after this byte, plus payload and trailing CRLF
    bulk_sum  = (NB + 2)'(cur_length) + (NB + 2)'(cur_num) + (NB + 2)'(rrd_pkg::CRLF_LEN + 1);
    bulk_over = bulk_sum > (NB + 2)'(cfg.max_request_length);
    star_bad  = cur_neg || (cur_num > NB'(arg_limit));
    seen_inc  = cur_seen + AB'(1);
    all_done  = seen_inc >= cur_expected;
  end

  // byte decode
  always_comb begin
    act = rrd_pkg::ACT_DISCARD;
    priority if (cur_phase == rrd_pkg::PH_ERROR) begin
      act = rrd_pkg::ACT_DISCARD;
    end else if (len_over) begin
      act = rrd_pkg::ACT_ERR_SIZE;
    end else begin
      unique case (cur_phase)
        rrd_pkg::PH_STAR: begin
          act = (cls == rrd_pkg::CLS_STAR) ? rrd_pkg::ACT_STAR_MARK : rrd_pkg::ACT_ERR_PROTO;
        end
        rrd_pkg::PH_TYPE: begin
          if (cls == rrd_pkg::CLS_DOLLAR)     act = rrd_pkg::ACT_LEN_MARK;
          else if (cls == rrd_pkg::CLS_COLON) act = rrd_pkg::ACT_INT_MARK;
          else                                act = rrd_pkg::ACT_ERR_PROTO;
        end
        rrd_pkg::PH_NUM_FIRST, rrd_pkg::PH_NUM_MORE: begin
          if (cls == rrd_pkg::CLS_DIGIT)
            act = num_over ? rrd_pkg::ACT_ERR_PROTO : rrd_pkg::ACT_DIGIT;
          else if (cur_phase == rrd_pkg::PH_NUM_FIRST && cls == rrd_pkg::CLS_MINUS && !cur_neg)
            act = rrd_pkg::ACT_SIGN;
          else if (cur_phase == rrd_pkg::PH_NUM_MORE && cls == rrd_pkg::CLS_CR)
            act = rrd_pkg::ACT_NUM_CR;
          else
            act = rrd_pkg::ACT_ERR_PROTO;
        end
        rrd_pkg::PH_NUM_LF: begin
          if (cls != rrd_pkg::CLS_LF) begin
            act = rrd_pkg::ACT_ERR_PROTO;
          end else begin
            unique case (cur_kind)
              rrd_pkg::KIND_LEN: begin
                if (!cur_neg)
                  act = bulk_over ? rrd_pkg::ACT_ERR_SIZE : rrd_pkg::ACT_LEN_DONE;
                else if (cur_num != NB'(1))
                  act = rrd_pkg::ACT_ERR_PROTO;
                else
                  act = rrd_pkg::ACT_ARG_DONE;   // null bulk string
              end
              rrd_pkg::KIND_INT: act = rrd_pkg::ACT_ARG_DONE;
              default: begin
                if (star_bad)             act = rrd_pkg::ACT_ERR_PROTO;
                else if (cur_num == '0)   act = rrd_pkg::ACT_STAR_EMPTY;
                else                      act = rrd_pkg::ACT_STAR_DONE;
              end
            endcase
          end
        end
        rrd_pkg::PH_PAYLOAD: act = rrd_pkg::ACT_PAYLOAD;
        rrd_pkg::PH_PAY_CR: begin
          act = (cls == rrd_pkg::CLS_CR) ? rrd_pkg::ACT_PAY_CR : rrd_pkg::ACT_ERR_PROTO;
        end
        rrd_pkg::PH_PAY_LF: begin
          act = (cls == rrd_pkg::CLS_LF) ? rrd_pkg::ACT_ARG_DONE : rrd_pkg::ACT_ERR_PROTO;
        end
        default: act = rrd_pkg::ACT_DISCARD;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next     = cur_phase;
    kind_next      = cur_kind;
    num_next       = cur_num;
    neg_next       = cur_neg;
    expected_next  = cur_expected;
    seen_next      = cur_seen;
    remaining_next = cur_remaining;
    length_next    = (cur_phase == rrd_pkg::PH_ERROR) ? cur_length : len_inc;
    error_next     = cur_error;
    clr            = 1'b0;
    clr_phase      = rrd_pkg::PH_STAR;

    unique case (act)
      rrd_pkg::ACT_DISCARD: ;
      rrd_pkg::ACT_ERR_PROTO: begin
        clr        = 1'b1;
        clr_phase  = rrd_pkg::PH_ERROR;
        error_next = rrd_pkg::ERR_PROTOCOL;
      end
      rrd_pkg::ACT_ERR_SIZE: begin
        clr        = 1'b1;
        clr_phase  = rrd_pkg::PH_ERROR;
        error_next = rrd_pkg::ERR_TOO_BIG;
      end
      rrd_pkg::ACT_STAR_MARK, rrd_pkg::ACT_LEN_MARK, rrd_pkg::ACT_INT_MARK: begin
        num_next   = '0;
        neg_next   = 1'b0;
        phase_next = rrd_pkg::PH_NUM_FIRST;
        if (act == rrd_pkg::ACT_LEN_MARK)      kind_next = rrd_pkg::KIND_LEN;
        else if (act == rrd_pkg::ACT_INT_MARK) kind_next = rrd_pkg::KIND_INT;
        else                                   kind_next = rrd_pkg::KIND_STAR;
      end
      rrd_pkg::ACT_SIGN:  neg_next = 1'b1;
      rrd_pkg::ACT_DIGIT: begin
        num_next   = num_wide[NB-1:0];
        phase_next = rrd_pkg::PH_NUM_MORE;
      end
      rrd_pkg::ACT_NUM_CR:     phase_next = rrd_pkg::PH_NUM_LF;
      rrd_pkg::ACT_STAR_EMPTY: clr = 1'b1;
      rrd_pkg::ACT_STAR_DONE: begin
        expected_next = cur_num[AB-1:0];
        seen_next     = '0;
        phase_next    = rrd_pkg::PH_TYPE;
      end
      rrd_pkg::ACT_LEN_DONE: begin
        // bulk size check bounds the length to LB bits
        remaining_next = cur_num[LB-1:0];
        phase_next     = (cur_num == '0) ? rrd_pkg::PH_PAY_CR : rrd_pkg::PH_PAYLOAD;
      end
      rrd_pkg::ACT_ARG_DONE: begin
        seen_next  = seen_inc;
        phase_next = rrd_pkg::PH_TYPE;
        clr        = all_done;
      end
      rrd_pkg::ACT_PAYLOAD: begin
        remaining_next = cur_remaining - LB'(1);
        if (cur_remaining == LB'(1)) phase_next = rrd_pkg::PH_PAY_CR;
      end
      rrd_pkg::ACT_PAY_CR: phase_next = rrd_pkg::PH_PAY_LF;
      default: ;
    endcase

    if (clr) begin
      phase_next     = clr_phase;
      kind_next      = rrd_pkg::KIND_STAR;
      num_next       = '0;
      neg_next       = 1'b0;
      expected_next  = '0;
      seen_next      = '0;
      remaining_next = '0;
      length_next    = '0;
    end
  end

  // result tagging
  always_comb begin
    res.echo_byte      = rd.entry.data_byte;
    res.role           = rrd_pkg::ROLE_DISCARD;
    res.argument_end   = 1'b0;
    res.request_end    = 1'b0;
    res.error_code     = error_next;
    unique case (act)
      rrd_pkg::ACT_DISCARD, rrd_pkg::ACT_ERR_PROTO, rrd_pkg::ACT_ERR_SIZE:
        res.role = rrd_pkg::ROLE_DISCARD;
      rrd_pkg::ACT_STAR_MARK, rrd_pkg::ACT_LEN_MARK, rrd_pkg::ACT_INT_MARK:
        res.role = rrd_pkg::ROLE_TYPE;
      rrd_pkg::ACT_SIGN, rrd_pkg::ACT_DIGIT:
        res.role = rrd_pkg::ROLE_NUM;
      rrd_pkg::ACT_PAYLOAD:
        res.role = rrd_pkg::ROLE_PAYLOAD;
      rrd_pkg::ACT_STAR_EMPTY: begin
        res.role        = rrd_pkg::ROLE_CRLF;
        res.request_end = 1'b1;
      end
      rrd_pkg::ACT_ARG_DONE: begin
        res.role         = rrd_pkg::ROLE_CRLF;
        res.argument_end = 1'b1;
        res.request_end  = all_done;
      end
      rrd_pkg::ACT_NUM_CR, rrd_pkg::ACT_STAR_DONE, rrd_pkg::ACT_LEN_DONE,
      rrd_pkg::ACT_PAY_CR:
        res.role = rrd_pkg::ROLE_CRLF;
      default: res.role = rrd_pkg::ROLE_DISCARD;
    endcase
    // the argument count is zero throughout a star header
    res.argument_index = (res.role == rrd_pkg::ROLE_DISCARD) ?
                         '0 : cur_seen[rrd_pkg::IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rrd_pkg::PH_STAR;
      kind        <= rrd_pkg::KIND_STAR;
      num         <= '0;
      neg         <= 1'b0;
      expected    <= '0;
      seen        <= '0;
      remaining   <= '0;
      length      <= '0;
      error_latch <= rrd_pkg::ERR_NONE;
      tag_valid   <= 1'b0;
    end else begin
      if (advance) begin
        phase       <= phase_next;
        kind        <= kind_next;
        num         <= num_next;
        neg         <= neg_next;
        expected    <= expected_next;
        seen        <= seen_next;
        remaining   <= remaining_next;
        length      <= length_next;
        error_latch <= error_next;
      end
      if (advance)         tag_valid <= 1'b1;
      else if (!tag_stall) tag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) tag_item <= res;
  end

  `RRD_ASSERT_IMP(a_err_only_in_error, phase != rrd_pkg::PH_ERROR, error_latch == rrd_pkg::ERR_NONE)
  `RRD_ASSERT_IMP(a_payload_left, phase == rrd_pkg::PH_PAYLOAD, remaining != '0)
  `RRD_ASSERT_IMP(a_err_discards, tag_valid && tag_item.error_code != rrd_pkg::ERR_NONE, tag_item.role == rrd_pkg::ROLE_DISCARD)

endmodule
